### rtl/djss_pkg.sv
// Shared types, codes and defaults of the dictionary JSON subset scanner.
`default_nettype none

package djss_pkg;

    localparam int MAX_TRANSLATIONS_DEF = 32;
    localparam int MAX_ENTRIES_DEF      = 1024;
    localparam int QUEUE_DEPTH_DEF      = 2;

    // Field widths of one result word.
    localparam int ROLE_W    = 3;
    localparam int EIDX_W    = 10;
    localparam int TIDX_W    = 5;
    localparam int ECOUNT_W  = 11;
    localparam int STATUS_W  = 3;

    // Character classes found by the front end.
    typedef logic [3:0] char_class_t;
    localparam char_class_t CL_WS     = 4'd0;
    localparam char_class_t CL_LBRACE = 4'd1;
    localparam char_class_t CL_RBRACE = 4'd2;
    localparam char_class_t CL_LBRACK = 4'd3;
    localparam char_class_t CL_RBRACK = 4'd4;
    localparam char_class_t CL_COLON  = 4'd5;
    localparam char_class_t CL_COMMA  = 4'd6;
    localparam char_class_t CL_QUOTE  = 4'd7;
    localparam char_class_t CL_OTHER  = 4'd8;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_SKIP     = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_KEYCHAR  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_TRCHAR   = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_KEYSTART = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_TRSTART  = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_CLOSE    = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_EMPTY    = 3'd6;

    // Parse status codes.
    localparam logic [STATUS_W-1:0] ST_PARSING   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SYNTAX    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STALLED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TEXT_OPEN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

    // One classified byte as it waits in the queue.
    typedef struct packed {
        char_class_t cls;
        logic        last;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ECOUNT_W-1:0] entry_count;
        logic                kept;
        logic [TIDX_W-1:0]   tr_index;
        logic [EIDX_W-1:0]   entry_index;
        logic [ROLE_W-1:0]   role;
    } result_t;

endpackage

`default_nettype wire

### rtl/djss_front.sv
// Front end: accepts text bytes and registers their character class.
`default_nettype none

module djss_front import djss_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    output logic            push_valid,
    input  wire logic       push_ready,
    output item_t           push_item
);

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t k;
        unique case (c) inside
            8'h20, 8'h0A, 8'h09, 8'h0D: k = CL_WS;
            8'h7B:                      k = CL_LBRACE;
            8'h7D:                      k = CL_RBRACE;
            8'h5B:                      k = CL_LBRACK;
            8'h5D:                      k = CL_RBRACK;
            8'h3A:                      k = CL_COLON;
            8'h2C:                      k = CL_COMMA;
            8'h22:                      k = CL_QUOTE;
            default:                    k = CL_OTHER;
        endcase
        return k;
    endfunction

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  accept;

    assign s_tready   = !valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= '{cls: classify(s_tdata), last: s_tlast};
        end
    end

endmodule

`default_nettype wire

### rtl/djss_queue.sv
// Short register queue between the front end and the parser.
`default_nettype none

module djss_queue import djss_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  item_t     in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output item_t     out_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

### rtl/djss_back.sv
// Parser back end: phase machine, entry and translation counters, result register.
`default_nettype none

module djss_back import djss_pkg::*; #(
    parameter int MAX_TRANSLATIONS = MAX_TRANSLATIONS_DEF,
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  item_t     in_item,
    output logic      res_valid,
    input  wire logic res_ready,
    output result_t   res
);

    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = $clog2(MAX_TRANSLATIONS + 1);
    localparam logic [EW-1:0] MAX_E = EW'(MAX_ENTRIES);
    localparam logic [TW-1:0] MAX_T = TW'(MAX_TRANSLATIONS);

    localparam logic [3:0] PH_OPEN        = 4'd0;
    localparam logic [3:0] PH_KEY         = 4'd1;
    localparam logic [3:0] PH_KEYSTR      = 4'd2;
    localparam logic [3:0] PH_COLON       = 4'd3;
    localparam logic [3:0] PH_ARR         = 4'd4;
    localparam logic [3:0] PH_ELEM        = 4'd5;
    localparam logic [3:0] PH_TRSTR       = 4'd6;
    localparam logic [3:0] PH_AFTER_TR    = 4'd7;
    localparam logic [3:0] PH_AFTER_ENTRY = 4'd8;
    localparam logic [3:0] PH_DONE        = 4'd9;

    logic [3:0]          phase_reg, phase_next;
    logic [EW-1:0]       ent_reg, ent_next;
    logic [TW-1:0]       tr_reg, tr_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic                valid_reg;
    result_t             res_reg, res_next;

    logic                pop, is_ws;
    logic [ROLE_W-1:0]   role;
    logic                in_tr, count_after, do_key, do_elem;
    logic [TW-1:0]       tcount;
    logic [EW-1:0]       eidx;
    logic [TW-1:0]       tidx;
    logic [31:0]         eidx_ext, tidx_ext, ecount_ext;

    assign in_ready  = !valid_reg || res_ready;
    assign pop       = in_valid && in_ready;
    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign is_ws     = (in_item.cls == CL_WS);

    always_comb begin
        role        = ROLE_SKIP;
        in_tr       = 1'b0;
        count_after = 1'b0;
        do_key      = 1'b0;
        do_elem     = 1'b0;
        tcount      = tr_reg;
        phase_next  = phase_reg;
        ent_next    = ent_reg;
        tr_next     = tr_reg;
        stat_next   = stat_reg;

        unique case (phase_reg)
            PH_OPEN: begin
                if (in_item.cls == CL_LBRACE) begin
                    phase_next = PH_KEY;
                end else if (!is_ws) begin
                    stat_next  = ST_SYNTAX;
                    phase_next = PH_DONE;
                end
            end
            PH_KEY: begin
                do_key = 1'b1;
            end
            PH_KEYSTR: begin
                if (in_item.cls == CL_QUOTE) begin
                    role       = ROLE_CLOSE;
                    phase_next = PH_COLON;
                end else begin
                    role = ROLE_KEYCHAR;
                end
            end
            PH_COLON: begin
                if (in_item.cls == CL_COLON) begin
                    phase_next = PH_ARR;
                end else if (!is_ws) begin
                    stat_next  = ST_SYNTAX;
                    phase_next = PH_DONE;
                end
            end
            PH_ARR: begin
                if (in_item.cls == CL_LBRACK) begin
                    tr_next    = '0;
                    tcount     = '0;
                    phase_next = PH_ELEM;
                end else if (!is_ws) begin
                    stat_next  = ST_SYNTAX;
                    phase_next = PH_DONE;
                end
            end
            PH_ELEM: begin
                do_elem = 1'b1;
            end
            PH_TRSTR: begin
                in_tr = 1'b1;
                if (in_item.cls == CL_QUOTE) begin
                    role        = ROLE_CLOSE;
                    count_after = 1'b1;
                    phase_next  = PH_AFTER_TR;
                end else begin
                    role = ROLE_TRCHAR;
                end
            end
            PH_AFTER_TR: begin
                if (in_item.cls == CL_COMMA) begin
                    phase_next = PH_ELEM;
                end else if (!is_ws) begin
                    do_elem = 1'b1;
                end
            end
            PH_AFTER_ENTRY: begin
                if (in_item.cls == CL_COMMA) begin
                    phase_next = PH_KEY;
                end else if (!is_ws) begin
                    do_key = 1'b1;
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // Byte inside an array, between translations.
        if (do_elem) begin
            unique case (in_item.cls)
                CL_WS: begin
                end
                CL_RBRACK: begin
                    if (ent_reg < MAX_E) begin
                        ent_next = ent_reg + 1'b1;
                    end
                    phase_next = PH_AFTER_ENTRY;
                end
                CL_QUOTE: begin
                    in_tr      = 1'b1;
                    role       = ROLE_TRSTART;
                    phase_next = PH_TRSTR;
                end
                CL_COMMA: begin
                    in_tr       = 1'b1;
                    role        = ROLE_EMPTY;
                    count_after = 1'b1;
                end
                default: begin
                    stat_next  = ST_STALLED;
                    phase_next = PH_DONE;
                end
            endcase
        end

        // Byte where a key is expected; a colon stands for an empty key.
        if (do_key) begin
            unique case (in_item.cls) inside
                CL_WS: begin
                end
                CL_RBRACE: begin
                    stat_next  = ST_CLOSED;
                    phase_next = PH_DONE;
                end
                CL_QUOTE, CL_COLON: begin
                    if (ent_reg >= MAX_E) begin
                        stat_next  = ST_OVERFLOW;
                        phase_next = PH_DONE;
                    end else if (in_item.cls == CL_COLON) begin
                        phase_next = PH_ARR;
                    end else begin
                        role       = ROLE_KEYSTART;
                        phase_next = PH_KEYSTR;
                    end
                end
                default: begin
                    stat_next  = ST_SYNTAX;
                    phase_next = PH_DONE;
                end
            endcase
        end

        if (count_after && (tr_reg < MAX_T)) begin
            tr_next = tr_reg + 1'b1;
        end

        eidx       = (ent_next < MAX_E) ? ent_next : MAX_E - 1'b1;
        tidx       = (tcount < MAX_T) ? tcount : MAX_T - 1'b1;
        eidx_ext   = 32'(eidx);
        tidx_ext   = 32'(tidx);
        ecount_ext = 32'(ent_next);

        res_next.role        = role;
        res_next.entry_index = eidx_ext[EIDX_W-1:0];
        res_next.tr_index    = in_tr ? tidx_ext[TIDX_W-1:0] : '0;
        res_next.kept        = in_tr && (tcount < MAX_T);
        res_next.entry_count = ecount_ext[ECOUNT_W-1:0];
        res_next.status      = (in_item.last && (stat_next == ST_PARSING)) ?
                               ST_TEXT_OPEN : stat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            ent_reg   <= '0;
            tr_reg    <= '0;
            stat_reg  <= ST_PARSING;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                if (in_item.last) begin
                    phase_reg <= PH_OPEN;
                    ent_reg   <= '0;
                    tr_reg    <= '0;
                    stat_reg  <= ST_PARSING;
                end else begin
                    phase_reg <= phase_next;
                    ent_reg   <= ent_next;
                    tr_reg    <= tr_next;
                    stat_reg  <= stat_next;
                end
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/dictionary_json_subset_scanner.sv
// Top level of the dictionary JSON subset scanner.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid, s_tready | s_tdata: char_byte; s_tlast: last
//  m_      | out | m_tvalid, m_tready | m_tdata: indices, counts, status; m_tuser: role
//
// One text byte is taken in every clock cycle unless the result side stalls, and one
// result word leaves for each byte, in order. The front register classifies the byte,
// a short queue decouples it from the parser, and the parser's phase machine and
// counters step once per word, so the sustained rate is one word per cycle. A byte's
// result passes the front register, a queue slot and the result register, in order.
// A stall on the result side fills the queue and then drops s_tready; nothing is
// lost. Reset is synchronous and active low.
// After a word with s_tlast set, the parser returns to its reset state.
`default_nettype none

module dictionary_json_subset_scanner import djss_pkg::*; #(
    parameter int MAX_TRANSLATIONS = MAX_TRANSLATIONS_DEF,
    parameter int MAX_ENTRIES      = MAX_ENTRIES_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] entry_index, [14:10] translation_index,
                                        // [15] translation_kept, [26:16] entry_count,
                                        // [29:27] status, [31:30] zero
    output logic [2:0]       m_tuser    // [2:0] role
);

    // Classified bytes leaving the front register.
    logic    fr_valid, fr_ready;
    item_t   fr_item;
    // Queue head toward the parser.
    logic    q_valid, q_ready;
    item_t   q_item;
    // Parser result register.
    result_t res;

    djss_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item)
    );

    djss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    djss_back #(
        .MAX_TRANSLATIONS (MAX_TRANSLATIONS),
        .MAX_ENTRIES      (MAX_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // The role travels in tuser; the rest is packed into tdata, lowest field first.
    assign m_tuser = res.role;
    assign m_tdata = {2'b00, res.status, res.entry_count, res.kept,
                      res.tr_index, res.entry_index};

endmodule

`default_nettype wire

### rtl/djss_checker.sv
// Port-level checker of the scanner, bound to the top level.
`default_nettype none

module djss_checker import djss_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    logic is_tr_role;
    assign is_tr_role = (m_tuser == ROLE_TRCHAR) || (m_tuser == ROLE_TRSTART) ||
                        (m_tuser == ROLE_CLOSE) || (m_tuser == ROLE_EMPTY);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Only translation bytes may report a kept translation.
    a_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> is_tr_role)
        else $error("kept flag on a non-translation byte");

    // A nonzero translation index belongs to a translation byte.
    a_tidx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[14:10] != '0) |-> is_tr_role)
        else $error("translation index on a non-translation byte");

    // A tagged byte is only reported while the parse is still running.
    a_role_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ROLE_SKIP) |->
            (m_tdata[29:27] == ST_PARSING) || (m_tdata[29:27] == ST_TEXT_OPEN))
        else $error("tagged byte after the parse stopped");

endmodule

bind dictionary_json_subset_scanner djss_checker u_djss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/dictionary_json_subset_scanner_tb.sv
// Self-checking testbench for the dictionary JSON subset scanner, with its own scanning predictor.
`timescale 1ns / 100ps

module dictionary_json_subset_scanner_tb;
    import djss_pkg::*;

    // The block runs with its default caps, so the predictor uses the same ones.
    localparam int TR_CAP       = MAX_TRANSLATIONS_DEF;
    localparam int ENTRY_CAP    = MAX_ENTRIES_DEF;
    localparam int RANDOM_BYTES = 1800;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLDOFF_AT   = 400;
    localparam int HOLDOFF_LEN  = 300;

    // Characters that carry meaning in the scanned text.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_X      = 8'h78;

    // Where the scanner stands within the text.
    typedef enum logic [3:0] {
        SEEK_BRACE, SEEK_KEY, KEY_TEXT, SEEK_COLON, SEEK_BRACKET,
        SEEK_ELEMENT, TRANSLATION_TEXT, AFTER_TRANSLATION, AFTER_ENTRY, HALTED
    } scan_phase_e;

    // One row of the directed probe: a byte, its end-of-text flag, and an optional
    // expected result that is typed in by hand instead of predicted.
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       typed;
        result_t    want;
    } probe_row_t;

    localparam result_t UNTYPED  = '0;
    // The opening brace right after reset: nothing counted, nothing tagged.
    localparam result_t AT_RESET = '0;
    // The closing brace of the probe text, after two complete entries.
    localparam result_t CLOSED_TWO = '{status: ST_CLOSED, entry_count: 11'd2, kept: 1'b0,
                                       tr_index: 5'd0, entry_index: 10'd2, role: ROLE_SKIP};
    // A stray letter inside the first array stalls the scan.
    localparam result_t STALLED_FIRST = '{status: ST_STALLED, entry_count: 11'd0, kept: 1'b0,
                                          tr_index: 5'd0, entry_index: 10'd0, role: ROLE_SKIP};

    // Directed text: a key made of the lowest byte, a translation made of the highest,
    // a translation that follows without a comma, an empty string, a bare comma, a
    // trailing comma before ']', a missing key after a missing comma, a trailing comma
    // before '}'. Then a short text with a stray byte inside an array.
    localparam probe_row_t PROBES [25] = '{
        '{CH_LBRACE, 1'b0, 1'b1, AT_RESET},
        '{CH_SPACE,  1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{8'h00,     1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{CH_COLON,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACK, 1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{8'hFF,     1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{CH_QUOTE,  1'b0, 1'b0, UNTYPED},
        '{CH_TAB,    1'b0, 1'b0, UNTYPED},
        '{CH_COMMA,  1'b0, 1'b0, UNTYPED},
        '{CH_COMMA,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACK, 1'b0, 1'b0, UNTYPED},
        '{CH_COLON,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACK, 1'b0, 1'b0, UNTYPED},
        '{CH_RBRACK, 1'b0, 1'b0, UNTYPED},
        '{CH_COMMA,  1'b0, 1'b0, UNTYPED},
        '{CH_RBRACE, 1'b1, 1'b1, CLOSED_TWO},
        '{CH_LBRACE, 1'b0, 1'b0, UNTYPED},
        '{CH_COLON,  1'b0, 1'b0, UNTYPED},
        '{CH_LBRACK, 1'b0, 1'b0, UNTYPED},
        '{CH_X,      1'b1, 1'b1, STALLED_FIRST}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [9:0] entry_index, [14:10] translation_index,
                                     // [15] translation_kept, [26:16] entry_count,
                                     // [29:27] status, [31:30] zero
    logic [2:0]  m_tuser;            // [2:0] role

    // Predictor state, mirroring the scanner's phase machine and counters.
    scan_phase_e         phase;
    int                  done_entries;
    int                  tr_count;
    logic [STATUS_W-1:0] stop_code;

    result_t     expected_results[$];
    logic [7:0]  text_bytes[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          live_bytes   = 0;
    int          burst_left   = 0;
    bit          steady       = 1'b0;
    int unsigned cycle_count  = 0;

    dictionary_json_subset_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_scan();
        phase        = SEEK_BRACE;
        done_entries = 0;
        tr_count     = 0;
        stop_code    = ST_PARSING;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void halt(input logic [STATUS_W-1:0] code);
        stop_code = code;
        phase     = HALTED;
    endfunction

    // A byte where an array element is expected.
    function automatic logic [ROLE_W-1:0] element_role(input logic [7:0] c,
                                                       output bit part_of_tr);
        part_of_tr = 1'b0;
        if (is_blank(c))
            return ROLE_SKIP;
        if (c == CH_RBRACK) begin
            if (done_entries < ENTRY_CAP)
                done_entries++;
            phase = AFTER_ENTRY;
            return ROLE_SKIP;
        end
        if (c == CH_QUOTE) begin
            part_of_tr = 1'b1;
            phase      = TRANSLATION_TEXT;
            return ROLE_TRSTART;
        end
        if (c == CH_COMMA) begin
            // A bare comma stands for an empty translation.
            part_of_tr = 1'b1;
            return ROLE_EMPTY;
        end
        // Anything else would never be consumed, so the scan stalls here.
        halt(ST_STALLED);
        return ROLE_SKIP;
    endfunction

    // A byte where a key, a colon standing for an empty key, or '}' is expected.
    function automatic logic [ROLE_W-1:0] key_role(input logic [7:0] c);
        if (is_blank(c))
            return ROLE_SKIP;
        if (c == CH_RBRACE) begin
            halt(ST_CLOSED);
            return ROLE_SKIP;
        end
        if (c == CH_QUOTE || c == CH_COLON) begin
            if (done_entries >= ENTRY_CAP) begin
                halt(ST_OVERFLOW);
                return ROLE_SKIP;
            end
            if (c == CH_COLON) begin
                phase = SEEK_BRACKET;
                return ROLE_SKIP;
            end
            phase = KEY_TEXT;
            return ROLE_KEYSTART;
        end
        halt(ST_SYNTAX);
        return ROLE_SKIP;
    endfunction

    // Steps the predictor by one byte and returns the result word that byte causes.
    function automatic result_t scan_predict(input logic [7:0] c, input bit lst);
        result_t             r;
        logic [ROLE_W-1:0]   rl;
        logic [STATUS_W-1:0] st;
        bit                  part_of_tr;
        bit                  bump;
        int                  tcount;
        int                  eidx;
        int                  tidx;
        rl         = ROLE_SKIP;
        part_of_tr = 1'b0;
        bump       = 1'b0;
        tcount     = tr_count;
        case (phase)
            SEEK_BRACE: begin
                if (c == CH_LBRACE)
                    phase = SEEK_KEY;
                else if (!is_blank(c))
                    halt(ST_SYNTAX);
            end
            SEEK_KEY: begin
                rl = key_role(c);
            end
            KEY_TEXT: begin
                if (c == CH_QUOTE) begin
                    rl    = ROLE_CLOSE;
                    phase = SEEK_COLON;
                end else begin
                    rl = ROLE_KEYCHAR;
                end
            end
            SEEK_COLON: begin
                if (c == CH_COLON)
                    phase = SEEK_BRACKET;
                else if (!is_blank(c))
                    halt(ST_SYNTAX);
            end
            SEEK_BRACKET: begin
                if (c == CH_LBRACK) begin
                    tr_count = 0;
                    tcount   = 0;
                    phase    = SEEK_ELEMENT;
                end else if (!is_blank(c)) begin
                    halt(ST_SYNTAX);
                end
            end
            SEEK_ELEMENT: begin
                rl   = element_role(c, part_of_tr);
                bump = (rl == ROLE_EMPTY);
            end
            TRANSLATION_TEXT: begin
                part_of_tr = 1'b1;
                if (c == CH_QUOTE) begin
                    rl    = ROLE_CLOSE;
                    bump  = 1'b1;
                    phase = AFTER_TRANSLATION;
                end else begin
                    rl = ROLE_TRCHAR;
                end
            end
            AFTER_TRANSLATION: begin
                // The comma between translations is optional.
                if (c == CH_COMMA) begin
                    phase = SEEK_ELEMENT;
                end else begin
                    rl   = element_role(c, part_of_tr);
                    bump = (rl == ROLE_EMPTY);
                end
            end
            AFTER_ENTRY: begin
                // The comma between entries is optional as well.
                if (c == CH_COMMA)
                    phase = SEEK_KEY;
                else
                    rl = key_role(c);
            end
            default: begin
                phase = HALTED;
            end
        endcase

        if (bump && tr_count < TR_CAP)
            tr_count++;

        st = stop_code;
        if (lst && st == ST_PARSING)
            st = ST_TEXT_OPEN;
        eidx = (done_entries < ENTRY_CAP) ? done_entries : ENTRY_CAP - 1;
        tidx = (tcount < TR_CAP) ? tcount : TR_CAP - 1;

        r.role        = rl;
        r.entry_index = eidx[EIDX_W-1:0];
        r.tr_index    = part_of_tr ? tidx[TIDX_W-1:0] : '0;
        r.kept        = part_of_tr && (tcount < TR_CAP);
        r.entry_count = done_entries[ECOUNT_W-1:0];
        r.status      = st;
        if (lst)
            clear_scan();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    // Any byte that may stand inside a quoted string, mostly printable.
    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do
            b = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic void add_blank();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: text_bytes.push_back(CH_SPACE);
                1: text_bytes.push_back(CH_LF);
                2: text_bytes.push_back(CH_TAB);
                default: text_bytes.push_back(CH_CR);
            endcase
        end
    endfunction

    function automatic void add_string(input int longest);
        text_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, longest)) text_bytes.push_back(text_char());
        text_bytes.push_back(CH_QUOTE);
    endfunction

    // A mostly well-formed dictionary with random keys, translations and separators.
    function automatic void build_dictionary();
        int n_entries;
        int n_tr;
        n_entries = $urandom_range(0, 4);
        text_bytes.push_back(CH_LBRACE);
        add_blank();
        for (int i = 0; i < n_entries; i++) begin
            // Now and then the key is left out and the colon comes straight away.
            if ($urandom_range(0, 6) != 0) begin
                add_string(4);
                add_blank();
            end
            text_bytes.push_back(CH_COLON);
            add_blank();
            text_bytes.push_back(CH_LBRACK);
            add_blank();
            n_tr = $urandom_range(0, 5);
            for (int j = 0; j < n_tr; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    text_bytes.push_back(CH_COMMA);
                end else begin
                    add_string(4);
                    add_blank();
                    // Commas mostly between translations, sometimes trailing.
                    if ((j < n_tr - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0))
                        text_bytes.push_back(CH_COMMA);
                end
                add_blank();
            end
            text_bytes.push_back(CH_RBRACK);
            add_blank();
            if ((i < n_entries - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 3) == 0))
                text_bytes.push_back(CH_COMMA);
            add_blank();
        end
        if ($urandom_range(0, 6) != 0)
            text_bytes.push_back(CH_RBRACE);
        // Bytes after the scan has stopped must be ignored until the end of text.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One entry with more translations than the cap allows.
    function automatic void build_crowded_entry();
        text_bytes.push_back(CH_LBRACE);
        add_string(2);
        text_bytes.push_back(CH_COLON);
        text_bytes.push_back(CH_LBRACK);
        repeat ($urandom_range(TR_CAP + 1, TR_CAP + 4)) begin
            if ($urandom_range(0, 1)) begin
                text_bytes.push_back(CH_COMMA);
            end else begin
                add_string(1);
                text_bytes.push_back(CH_COMMA);
            end
        end
        text_bytes.push_back(CH_RBRACK);
        text_bytes.push_back(CH_RBRACE);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one word, waits until it is taken, and records what it should produce.
    // Called in the time step of a rising edge; returns in the step of acceptance.
    task automatic push_byte(input logic [7:0] c, input bit lst, input bit typed,
                             input result_t want);
        result_t predicted;
        bit      live;
        int      gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        live      = (phase != HALTED);
        predicted = scan_predict(c, lst);
        expected_results.push_back(typed ? want : predicted);
        if (live)
            live_bytes++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            push_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, UNTYPED);
        text_bytes.delete();
    endtask

    // The sender stops offering and waits until every pending result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        int pick;
        clear_scan();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed probe, each byte either typed in or predicted.
        for (int i = 0; i < 25; i++)
            push_byte(PROBES[i].ch, PROBES[i].lst, PROBES[i].typed, PROBES[i].want);
        drain();

        // Fill every entry slot with empty keys and empty arrays, so the entry count
        // saturates, then offer one more key to force the overflow stop.
        steady = 1'b0;
        text_bytes.push_back(CH_LBRACE);
        repeat (ENTRY_CAP) begin
            text_bytes.push_back(CH_COLON);
            text_bytes.push_back(CH_LBRACK);
            text_bytes.push_back(CH_RBRACK);
        end
        text_bytes.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_COLON);
        text_bytes.push_back(CH_COMMA);
        send_text();
        drain();

        // Random texts: mostly well-formed, some damaged, some pure noise, and a few
        // entries that run past the translation cap.
        live_bytes = 0;
        while (live_bytes < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 68) begin
                build_dictionary();
            end else if (pick < 84) begin
                build_dictionary();
                if ($urandom_range(0, 1))
                    text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
                else
                    repeat ($urandom_range(0, text_bytes.size() - 1)) void'(text_bytes.pop_back());
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_crowded_entry();
            end
            send_text();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("dictionary_json_subset_scanner_tb passed");
        else
            $display("dictionary_json_subset_scanner_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern, and once holds off for a long stretch so
    // that the block's queue fills and it stops taking words.
    // ------------------------------------------------------------------

    initial begin
        int  pattern_left;
        int  mode;
        bit  held_off;
        pattern_left = 0;
        mode         = 0;
        held_off     = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= HOLDOFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge aclk);
            end
            if (pattern_left == 0) begin
                mode         = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: every word taken from the block is compared with the oldest
    // expectation, field by field, padding bits included.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.role        = m_tuser;
            got.entry_index = m_tdata[9:0];
            got.tr_index    = m_tdata[14:10];
            got.kept        = m_tdata[15];
            got.entry_count = m_tdata[26:16];
            got.status      = m_tdata[29:27];
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d arrived with no expectation pending: tdata %h tuser %0d",
                             results_seen, m_tdata, m_tuser);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[31:30] !== 2'b00) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d (expected/actual): role %0d/%0d entry %0d/%0d ",
                                  "tr %0d/%0d kept %0d/%0d count %0d/%0d status %0d/%0d pad %0d"},
                                 results_seen, want.role, got.role,
                                 want.entry_index, got.entry_index,
                                 want.tr_index, got.tr_index, want.kept, got.kept,
                                 want.entry_count, got.entry_count,
                                 want.status, got.status, m_tdata[31:30]);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dictionary_json_subset_scanner_tb failed");
            $finish;
        end
    end

endmodule

### dictionary_json_subset_scanner.f
rtl/djss_pkg.sv
rtl/djss_front.sv
rtl/djss_queue.sv
rtl/djss_back.sv
rtl/dictionary_json_subset_scanner.sv
rtl/djss_checker.sv
verif/dictionary_json_subset_scanner_tb.sv
